// ===== design/rgb_to_cmyk_converter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// rgb to cmyk converter assertion macros
// Shared assertion forms for the checker of the converter unit.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_CMYK_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_CMYK_CONVERTER_UNIT_DEFINES_SVH

// concurrent assertion on the rising clock, quiet while reset is high
`define RTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// concurrent assertion on the rising clock that also runs through reset
`define RTC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/rtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants and the restoring division step of the converter.
// ----------------------------------------------------------------------------
package rtc_pkg;

   // default number of fraction bits of the cmyk outputs
   localparam int FracBitsDefault = 16;

   // pixel channel and output field widths
   localparam int ChanWidth = 8;
   localparam int OutWidth  = 17;

   // largest channel value, divisor of the key lane
   localparam logic [ChanWidth-1:0] ChanMax = 8'd255;

   // divider lanes: cyan, magenta, yellow, key
   localparam int NumLanes  = 4;
   localparam int CyanLane  = 0;
   localparam int MagLane   = 1;
   localparam int YellLane  = 2;
   localparam int KeyLane   = 3;

   typedef logic [ChanWidth-1:0]               chan_type;
   typedef logic [NumLanes-1:0][ChanWidth-1:0] lane_rem_type;

   // one restoring division step: doubles the remainder, returns {bit, remainder}
   function automatic logic [ChanWidth:0] div_step(chan_type rem, chan_type den);
      logic [ChanWidth:0] trial;
      logic [ChanWidth:0] den_ext;
      logic [ChanWidth:0] diff;
      trial   = {rem, 1'b0};
      den_ext = {1'b0, den};
      diff    = trial - den_ext;
      if (trial >= den_ext) begin
         div_step = {1'b1, diff[ChanWidth-1:0]};
      end else begin
         div_step = {1'b0, trial[ChanWidth-1:0]};
      end
   endfunction

endpackage

// ===== design/rtc_front.sv =====
// ----------------------------------------------------------------------------
// rtc_front
// Entry stage: finds the largest channel, forms the four dividends and the
// divisor, resolves the integer quotient bit and registers the result.
// ----------------------------------------------------------------------------
module rtc_front
   import rtc_pkg::*;
#(
   parameter int QUO_WIDTH = FracBitsDefault + 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_stall,
   input  chan_type                           up_red,
   input  chan_type                           up_green,
   input  chan_type                           up_blue,
   output logic                               dn_valid,
   input  logic                               dn_stall,
   output chan_type                           dn_den,
   output lane_rem_type                       dn_rem,
   output logic [NumLanes-1:0][QUO_WIDTH-1:0] dn_quo
);

   logic                               valid_ff, valid_in;
   chan_type                           den_ff, den_in;
   lane_rem_type                       rem_ff, rem_in;
   logic [NumLanes-1:0][QUO_WIDTH-1:0] quo_ff, quo_in;
   chan_type                           max_rg, max_all;
   chan_type [NumLanes-1:0]            num;
   chan_type [NumLanes-1:0]            lane_den;
   logic                               load;

   // stage handshake
   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // largest channel and dividends; a black pixel divides 0 by 1
   always_comb begin
      max_rg   = (up_red > up_green) ? up_red : up_green;
      max_all  = (max_rg > up_blue) ? max_rg : up_blue;
      den_in   = (max_all == '0) ? chan_type'(1) : max_all;
      num[CyanLane]      = max_all - up_red;
      num[MagLane]       = max_all - up_green;
      num[YellLane]      = max_all - up_blue;
      num[KeyLane]       = ChanMax - max_all;
      lane_den[CyanLane] = den_in;
      lane_den[MagLane]  = den_in;
      lane_den[YellLane] = den_in;
      lane_den[KeyLane]  = ChanMax;
      // dividend never exceeds divisor, so the integer bit is an equality
      for (int i = 0; i < NumLanes; i++) begin
         quo_in[i] = QUO_WIDTH'(num[i] == lane_den[i]);
         rem_in[i] = (num[i] == lane_den[i]) ? '0 : num[i];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         den_ff <= den_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_den   = den_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;

endmodule

// ===== design/rtc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rtc_div_cell
// One cell of the divider chain: adds one fraction bit to each of the four
// quotients and passes remainders and divisor to the next cell.
// ----------------------------------------------------------------------------
module rtc_div_cell
   import rtc_pkg::*;
#(
   parameter int QUO_WIDTH = FracBitsDefault + 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_stall,
   input  chan_type                           up_den,
   input  lane_rem_type                       up_rem,
   input  logic [NumLanes-1:0][QUO_WIDTH-1:0] up_quo,
   output logic                               dn_valid,
   input  logic                               dn_stall,
   output chan_type                           dn_den,
   output lane_rem_type                       dn_rem,
   output logic [NumLanes-1:0][QUO_WIDTH-1:0] dn_quo
);

   logic                               valid_ff, valid_in;
   chan_type                           den_ff;
   lane_rem_type                       rem_ff, rem_in;
   logic [NumLanes-1:0][QUO_WIDTH-1:0] quo_ff, quo_in;
   logic [NumLanes-1:0][ChanWidth:0]   step;
   logic                               load;

   // stage handshake
   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // one division step per lane, the key lane divides by the channel maximum
   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         step[i]   = div_step(up_rem[i], (i == KeyLane) ? ChanMax : up_den);
         rem_in[i] = step[i][ChanWidth-1:0];
         quo_in[i] = {up_quo[i][QUO_WIDTH-2:0], step[i][ChanWidth]};
      end
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         den_ff <= up_den;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_den   = den_ff;
   assign dn_rem   = rem_ff;
   assign dn_quo   = quo_ff;

endmodule

// ===== design/rtc_round_out.sv =====
// ----------------------------------------------------------------------------
// rtc_round_out
// Output stage: rounds the quotients carrying one extra bit to nearest and
// holds the cmyk transaction for the receiver.
// ----------------------------------------------------------------------------
module rtc_round_out
   import rtc_pkg::*;
#(
   parameter int QUO_WIDTH = FracBitsDefault + 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               up_valid,
   output logic                               up_stall,
   input  logic [NumLanes-1:0][QUO_WIDTH-1:0] up_quo,
   output logic                               dn_valid,
   input  logic                               dn_stall,
   output logic [NumLanes-1:0][OutWidth-1:0]  dn_frac
);

   logic                               valid_ff, valid_in;
   logic [NumLanes-1:0][OutWidth-1:0]  frac_ff, frac_in;
   logic [NumLanes-1:0][QUO_WIDTH:0]   sum;
   logic                               load;

   // stage handshake
   assign up_stall = valid_ff & dn_stall;
   assign load     = up_valid & ~up_stall;
   assign valid_in = up_stall ? valid_ff : up_valid;

   // add half and drop the extra bit, keep the low output bits
   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         sum[i]     = (QUO_WIDTH+1)'(up_quo[i]) + (QUO_WIDTH+1)'(1);
         frac_in[i] = OutWidth'(sum[i][QUO_WIDTH:1]);
      end
   end

   // output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frac_ff <= frac_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_frac  = frac_ff;

endmodule

// ===== design/rgb_to_cmyk_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_cmyk_converter_unit
// Pixel converter from 8-bit rgb to cmyk fixed-point fractions.
// ----------------------------------------------------------------------------
// The req channel carries one rgb pixel per transaction; the rsp channel
// returns cyan, magenta, yellow and black_key, each an unsigned fraction
// with FRAC_BITS fraction bits where 2^FRAC_BITS means 1.0, rounded to
// nearest. A black pixel gives zero cyan, magenta and yellow and full key.
// Both channels use valid and stall; a transaction moves on a clock edge
// with valid high and stall low.
// The pipeline holds one entry stage, a chain of FRAC_BITS + 1 divider
// cells that each resolve one quotient bit for all four fractions, and one
// rounding output stage.
// Throughput is one pixel per cycle while rsp_stall is low; every stage
// then passes its transaction on, so the chain length sets latency only.
// When rsp_stall is high the output stage holds its transaction and the
// stall backs up only through stages that are occupied, so empty stages
// keep filling; req_stall rises once the whole chain is full.
// Synchronous reset empties all stages; no transaction survives it.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_converter_unit
   import rtc_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ChanWidth-1:0] req_red,
   input  logic [ChanWidth-1:0] req_green,
   input  logic [ChanWidth-1:0] req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OutWidth-1:0]  rsp_cyan,
   output logic [OutWidth-1:0]  rsp_magenta,
   output logic [OutWidth-1:0]  rsp_yellow,
   output logic [OutWidth-1:0]  rsp_black_key
);

   localparam int NumCells = FRAC_BITS + 1;
   localparam int QuoWidth = FRAC_BITS + 2;

   // links between stages: index 0 is the entry stage, NumCells the last cell
   logic                              link_valid [NumCells+1];
   logic                              link_stall [NumCells+1];
   chan_type                          link_den   [NumCells+1];
   lane_rem_type                      link_rem   [NumCells+1];
   logic [NumLanes-1:0][QuoWidth-1:0] link_quo   [NumCells+1];
   logic [NumLanes-1:0][OutWidth-1:0] frac;

   // entry stage
   rtc_front #(
      .QUO_WIDTH (QuoWidth)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_red   (req_red),
      .up_green (req_green),
      .up_blue  (req_blue),
      .dn_valid (link_valid[0]),
      .dn_stall (link_stall[0]),
      .dn_den   (link_den[0]),
      .dn_rem   (link_rem[0]),
      .dn_quo   (link_quo[0])
   );

   // divider chain, one fraction bit per cell
   for (genvar c = 0; c < NumCells; c++) begin : g_cell
      rtc_div_cell #(
         .QUO_WIDTH (QuoWidth)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[c]),
         .up_stall (link_stall[c]),
         .up_den   (link_den[c]),
         .up_rem   (link_rem[c]),
         .up_quo   (link_quo[c]),
         .dn_valid (link_valid[c+1]),
         .dn_stall (link_stall[c+1]),
         .dn_den   (link_den[c+1]),
         .dn_rem   (link_rem[c+1]),
         .dn_quo   (link_quo[c+1])
      );
   end

   // rounding and output register
   rtc_round_out #(
      .QUO_WIDTH (QuoWidth)
   ) u_round_out (
      .clock    (clock),
      .reset    (reset),
      .up_valid (link_valid[NumCells]),
      .up_stall (link_stall[NumCells]),
      .up_quo   (link_quo[NumCells]),
      .dn_valid (rsp_valid),
      .dn_stall (rsp_stall),
      .dn_frac  (frac)
   );

   // the last cell's remainders and divisor are spent
   logic unused_tail;
   assign unused_tail = ^{link_den[NumCells], link_rem[NumCells]};

   assign rsp_cyan      = frac[CyanLane];
   assign rsp_magenta   = frac[MagLane];
   assign rsp_yellow    = frac[YellLane];
   assign rsp_black_key = frac[KeyLane];

endmodule

// ===== design/rtc_checker.sv =====
// ----------------------------------------------------------------------------
// rtc_checker
// Port-level checks of the converter unit, bound onto the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_cmyk_converter_unit_defines.svh"

module rtc_checker
   import rtc_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [ChanWidth-1:0] req_red,
   input logic [ChanWidth-1:0] req_green,
   input logic [ChanWidth-1:0] req_blue,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OutWidth-1:0]  rsp_cyan,
   input logic [OutWidth-1:0]  rsp_magenta,
   input logic [OutWidth-1:0]  rsp_yellow,
   input logic [OutWidth-1:0]  rsp_black_key
);

   localparam logic [OutWidth-1:0] FullKey  = OutWidth'(64'd1 << FRAC_BITS);
   localparam logic                KeyFits  = (FRAC_BITS < OutWidth);

   logic unused_req;
   assign unused_req = ^{req_valid, req_stall, req_red, req_green, req_blue};

   // reset leaves no transaction in the chain
   `RTC_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "rsp_valid after reset")

   // a stalled response keeps its transaction
   `RTC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cyan) && $stable(rsp_magenta) && $stable(rsp_yellow) && $stable(rsp_black_key), "stalled response changed")

   // the largest channel always yields a zero fraction
   `RTC_ASSERT(a_max_lane_zero, rsp_valid |-> rsp_cyan == '0 || rsp_magenta == '0 || rsp_yellow == '0, "no zero color fraction")

   // a full key means a black pixel with no color
   `RTC_ASSERT(a_black_pixel, rsp_valid && KeyFits && rsp_black_key == FullKey |-> rsp_cyan == '0 && rsp_magenta == '0 && rsp_yellow == '0, "black pixel with color")

endmodule

bind rgb_to_cmyk_converter_unit rtc_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_rtc_checker (.*);

// ===== bench/rgb_to_cmyk_converter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_cmyk_converter_unit_tb
// Self-checking bench for the rgb to cmyk pixel converter. A short table of
// pixels covers black, white, primaries and corner values. Random pixels
// follow under three idle patterns, with one long output hold-off and two
// full drains. Every response is compared with table cmyk or a fixed-point cmyk predictor.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_converter_unit_tb;
   import rtc_pkg::*;

   localparam int FracBits      = FracBitsDefault;
   localparam int PhaseItems    = 650;
   localparam int HoldCycles    = 80;
   localparam int DrainTail     = FracBits + 12;
   localparam int WatchdogLimit = 2000;
   localparam int NumDirected   = 22;

   localparam logic [OutWidth-1:0] Unity = OutWidth'(64'd1 << FracBits);
   localparam logic [OutWidth-1:0] Zero  = '0;

   typedef struct packed {
      logic [OutWidth-1:0] cyan;
      logic [OutWidth-1:0] magenta;
      logic [OutWidth-1:0] yellow;
      logic [OutWidth-1:0] black_key;
   } cmyk_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      bit       known;
      cmyk_type want;
   } pixel_row_type;

   // directed pixels; known rows carry their cmyk, the rest use the predictor
   localparam pixel_row_type PixelTable [NumDirected] = '{
      '{8'd0,   8'd0,   8'd0,   1'b1, '{Zero,  Zero,  Zero,  Unity}}, // black
      '{8'd255, 8'd255, 8'd255, 1'b1, '{Zero,  Zero,  Zero,  Zero}},  // white
      '{8'd255, 8'd0,   8'd0,   1'b1, '{Zero,  Unity, Unity, Zero}},
      '{8'd0,   8'd255, 8'd0,   1'b1, '{Unity, Zero,  Unity, Zero}},
      '{8'd0,   8'd0,   8'd255, 1'b1, '{Unity, Unity, Zero,  Zero}},
      '{8'd255, 8'd255, 8'd0,   1'b1, '{Zero,  Zero,  Unity, Zero}},
      '{8'd0,   8'd255, 8'd255, 1'b1, '{Unity, Zero,  Zero,  Zero}},
      '{8'd255, 8'd0,   8'd255, 1'b1, '{Zero,  Unity, Zero,  Zero}},
      '{8'd1,   8'd0,   8'd0,   1'b0, '0},
      '{8'd0,   8'd1,   8'd0,   1'b0, '0},
      '{8'd0,   8'd0,   8'd1,   1'b0, '0},
      '{8'd1,   8'd1,   8'd1,   1'b0, '0},
      '{8'd128, 8'd128, 8'd128, 1'b0, '0},
      '{8'd254, 8'd254, 8'd254, 1'b0, '0},
      '{8'd255, 8'd254, 8'd1,   1'b0, '0},
      '{8'd85,  8'd170, 8'd255, 1'b0, '0},
      '{8'd3,   8'd2,   8'd1,   1'b0, '0},
      '{8'd170, 8'd85,  8'd170, 1'b0, '0},
      '{8'd85,  8'd170, 8'd85,  1'b0, '0},
      '{8'd200, 8'd100, 8'd50,  1'b0, '0},
      '{8'd254, 8'd0,   8'd127, 1'b0, '0},
      '{8'd0,   8'd128, 8'd255, 1'b0, '0}
   };

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ChanWidth-1:0] req_red   = '0;
   logic [ChanWidth-1:0] req_green = '0;
   logic [ChanWidth-1:0] req_blue  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OutWidth-1:0]  rsp_cyan;
   logic [OutWidth-1:0]  rsp_magenta;
   logic [OutWidth-1:0]  rsp_yellow;
   logic [OutWidth-1:0]  rsp_black_key;

   cmyk_type cmyk_pending [$];
   int    mismatch_count = 0;
   int    req_idle_pct   = 0;
   int    rsp_stall_pct  = 0;
   bit    hold_request   = 1'b0;
   int    quiet_cycles   = 0;

   rgb_to_cmyk_converter_unit #(
      .FRAC_BITS(FracBits)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cyan      (rsp_cyan),
      .rsp_magenta   (rsp_magenta),
      .rsp_yellow    (rsp_yellow),
      .rsp_black_key (rsp_black_key)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(num * 2^FracBits / den), ties up, cut to the output width
   function automatic logic [OutWidth-1:0] scaled_ratio(input logic [63:0] num,
                                                        input logic [63:0] den);
      logic [63:0] twice;
      logic [63:0] quotient;
      twice    = (num << FracBits) << 1;
      quotient = (twice + den) / (den << 1);
      return quotient[OutWidth-1:0];
   endfunction

   // cmyk fractions of one pixel
   function automatic cmyk_type cmyk_of_rgb(input chan_type r, input chan_type g,
                                            input chan_type b);
      chan_type peak;
      cmyk_type res;
      peak = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;
      if (peak == '0) begin
         // black pixel: no ink fractions, full key
         res.cyan      = Zero;
         res.magenta   = Zero;
         res.yellow    = Zero;
         res.black_key = Unity;
      end else begin
         res.cyan      = scaled_ratio(64'(peak - r), 64'(peak));
         res.magenta   = scaled_ratio(64'(peak - g), 64'(peak));
         res.yellow    = scaled_ratio(64'(peak - b), 64'(peak));
         res.black_key = scaled_ratio(64'(ChanMax - peak), 64'(ChanMax));
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // offer one pixel transaction, hold it until taken, then queue its cmyk
   task automatic offer_pixel(input chan_type r, input chan_type g, input chan_type b,
                              input bit known, input cmyk_type typed);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      cmyk_pending.push_back(known ? typed : cmyk_of_rgb(r, g, b));
   endtask

   // random pixel with a bias toward gray, near black and saturated channels
   task automatic offer_random_pixel();
      chan_type r;
      chan_type g;
      chan_type b;
      r = chan_type'($urandom_range(255));
      g = chan_type'($urandom_range(255));
      b = chan_type'($urandom_range(255));
      case ($urandom_range(9))
         4: begin
            g = r;
            b = r;
         end
         5: begin
            r = chan_type'($urandom_range(3));
            g = chan_type'($urandom_range(3));
            b = chan_type'($urandom_range(3));
         end
         6: begin
            case ($urandom_range(2))
               0: r = ChanMax;
               1: g = ChanMax;
               default: b = ChanMax;
            endcase
         end
         7: begin
            r = $urandom_range(1) ? ChanMax : '0;
            g = $urandom_range(1) ? ChanMax : '0;
            b = $urandom_range(1) ? ChanMax : '0;
         end
         8: begin
            g = r;
         end
         default: ;
      endcase
      offer_pixel(r, g, b, 1'b0, '0);
   endtask

   // output side: random stalls, plus a long hold-off on request
   initial begin : rsp_driver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) begin
            hold_left    = HoldCycles;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // compare each response transaction with the oldest pending cmyk
   always @(posedge clock) begin
      cmyk_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (cmyk_pending.size() == 0) begin
            report_mismatch("response with no pixel pending");
         end else begin
            want = cmyk_pending.pop_front();
            if (rsp_cyan !== want.cyan)
               report_mismatch($sformatf("cyan %0d, want %0d", rsp_cyan, want.cyan));
            if (rsp_magenta !== want.magenta)
               report_mismatch($sformatf("magenta %0d, want %0d",
                                         rsp_magenta, want.magenta));
            if (rsp_yellow !== want.yellow)
               report_mismatch($sformatf("yellow %0d, want %0d",
                                         rsp_yellow, want.yellow));
            if (rsp_black_key !== want.black_key)
               report_mismatch($sformatf("black_key %0d, want %0d",
                                         rsp_black_key, want.black_key));
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall == 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall == 1'b0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("rgb_to_cmyk_converter_unit_tb NOT OK");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table, then random, sender idles lightly, receiver heavily
      req_idle_pct  = 26;
      rsp_stall_pct = 58;
      for (int i = 0; i < NumDirected; i++) begin
         offer_pixel(PixelTable[i].red, PixelTable[i].green, PixelTable[i].blue,
                     PixelTable[i].known, PixelTable[i].want);
      end
      repeat (PhaseItems - NumDirected) offer_random_pixel();

      // swapped idle rates
      req_idle_pct  = 58;
      rsp_stall_pct = 26;
      repeat (PhaseItems) offer_random_pixel();

      // sender pauses until every pending response is back
      req_valid <= 1'b0;
      @(posedge clock);
      while (cmyk_pending.size() != 0) @(posedge clock);

      // no idling; long receiver hold-off at the start fills the pipeline
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_request  = 1'b1;
      repeat (PhaseItems) offer_random_pixel();

      req_valid <= 1'b0;
      while (cmyk_pending.size() != 0) @(posedge clock);
      repeat (DrainTail) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("rgb_to_cmyk_converter_unit_tb OK");
      end else begin
         $display("rgb_to_cmyk_converter_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
